FILE: src/voxel_line_cell_walker_assert.svh
`ifndef VOXEL_LINE_CELL_WALKER_ASSERT_SVH
`define VOXEL_LINE_CELL_WALKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define VLCW_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define VLCW_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vlcw_pkg.sv
package vlcw_pkg;

    localparam int GRID_DIM = 64;
    localparam int COORD_W  = 6;
    localparam int SIZE_W   = 7;
    localparam int INDEX_W  = 18;
    localparam int ERR_W    = 9;
    localparam int ROW_W    = COORD_W + SIZE_W;
    localparam int PROD_W   = ROW_W + SIZE_W;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    localparam logic [SIZE_W-1:0] GRID_DIM_SZ = SIZE_W'(GRID_DIM);

    typedef logic [COORD_W-1:0] coord_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic init;
        logic step;
    } vlcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic span_zero;
        logic step_last;
        logic pipe_en;
    } vlcw_stat_t;

endpackage

FILE: src/voxel_line_cell_walker.sv
// The input beat is taken in ST_IDLE; the sequencer then passes ST_SETUP and
// ST_INIT, and each ST_WALK step feeds stage 0, stage 1 and the output register,
// one cell per cycle while m_tready stays high. A segment of dominant-axis
// length n holds the walk sequencer for setup, init and max(n,1) walk steps; the next input beat is taken after that.
// Reset: rst_n (async, active low) idles the sequencer, empties the pipeline
// and sets the grid size to 64.
module voxel_line_cell_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    // start_x, start_y, start_z, end_x, end_y, end_z (6 bits each), zero pad
    input  logic [vlcw_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cell_x, cell_y, cell_z (6 bits each), cell_index (18 bits), zero pad
    output logic [vlcw_pkg::M_DATA_W-1:0] m_tdata,
    // in_grid, has_cell
    output logic [vlcw_pkg::M_USER_W-1:0] m_tuser,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // grid_size
    input  logic [vlcw_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);
    import vlcw_pkg::*;

    vlcw_cmd_t  cmd;
    vlcw_stat_t stat;

    // Grid size register takes a write every cycle
    assign cfg_ready = 1'b1;

    vlcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vlcw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: src/vlcw_ctrl.sv
module vlcw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output vlcw_pkg::vlcw_cmd_t  cmd,
    input  vlcw_pkg::vlcw_stat_t stat
);
    import vlcw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one segment: load, measure, seed errors, then walk
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.pipe_en)
                begin
                    cmd.step = 1'b1;
                    if (stat.span_zero || stat.step_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

FILE: src/vlcw_dp.sv
module vlcw_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vlcw_pkg::vlcw_cmd_t               cmd,
    output vlcw_pkg::vlcw_stat_t              stat,
    input  logic [vlcw_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              cfg_valid,
    input  logic [vlcw_pkg::SIZE_W-1:0]       cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vlcw_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [vlcw_pkg::M_USER_W-1:0]     m_tuser,
    output logic                              m_tlast
);
    import vlcw_pkg::*;

    // Effective grid size, saturated at GRID_DIM
    logic [SIZE_W-1:0] d_reg;

    // Walk state
    coord_t                   pos_reg   [3];
    coord_t                   end_reg   [3];
    coord_t                   dif_reg   [3];
    logic   [2:0]             dir_reg;
    logic   [2:0]             major_reg;
    coord_t                   dmaj_reg;
    logic signed [ERR_W-1:0]  err_reg   [3];
    coord_t                   cnt_reg;

    // Setup and step logic
    coord_t                   dif_next  [3];
    logic   [2:0]             dir_next;
    logic   [2:0]             major_next;
    coord_t                   dmaj_next;
    logic signed [ERR_W-1:0]  two_d     [3];
    logic signed [ERR_W-1:0]  two_dmaj;
    logic signed [ERR_W-1:0]  err_seed  [3];
    logic signed [ERR_W-1:0]  err_step  [3];
    coord_t                   pos_step  [3];

    // Pipeline: stage 0 cell, stage 1 row product, output register
    logic                     pipe_en;
    logic                     s0_valid_reg;
    coord_t                   s0_cell_reg [3];
    logic                     s0_has_reg;
    logic                     s0_last_reg;
    logic                     s1_valid_reg;
    coord_t                   s1_cell_reg [3];
    logic [ROW_W-1:0]         s1_row_reg;
    logic                     s1_ing_reg;
    logic                     s1_has_reg;
    logic                     s1_last_reg;
    logic                     out_valid_reg;
    coord_t                   out_cell_reg [3];
    logic [INDEX_W-1:0]       out_index_reg;
    logic                     out_ing_reg;
    logic                     out_has_reg;
    logic                     out_last_reg;

    logic [ROW_W-1:0]         row_next;
    logic                     ing_next;
    logic [PROD_W-1:0]        idx_full;

    // Measure spans and directions, pick the dominant axis
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            dir_next[a] = (end_reg[a] > pos_reg[a]);
            dif_next[a] = dir_next[a] ? (end_reg[a] - pos_reg[a])
                                      : (pos_reg[a] - end_reg[a]);
        end
        if (dif_next[0] >= dif_next[1] && dif_next[0] >= dif_next[2])
        begin
            major_next = 3'b001;
            dmaj_next  = dif_next[0];
        end
        else if (dif_next[1] >= dif_next[0] && dif_next[1] >= dif_next[2])
        begin
            major_next = 3'b010;
            dmaj_next  = dif_next[1];
        end
        else
        begin
            major_next = 3'b100;
            dmaj_next  = dif_next[2];
        end
    end

    // Seed the error terms and compute one step of the walk
    assign two_dmaj = ERR_W'({dmaj_reg, 1'b0});

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            two_d[a]    = ERR_W'({dif_reg[a], 1'b0});
            err_seed[a] = two_d[a] - ERR_W'(dmaj_reg);
            err_step[a] = err_reg[a] + two_d[a];
            pos_step[a] = pos_reg[a];
            if (major_reg[a])
            begin
                pos_step[a] = dir_reg[a] ? pos_reg[a] + COORD_W'(1)
                                         : pos_reg[a] - COORD_W'(1);
            end
            else if (err_reg[a] >= 0)
            begin
                pos_step[a] = dir_reg[a] ? pos_reg[a] + COORD_W'(1)
                                         : pos_reg[a] - COORD_W'(1);
                err_step[a] = err_reg[a] - two_dmaj + two_d[a];
            end
        end
    end

    assign pipe_en        = !out_valid_reg || m_tready;
    assign stat.pipe_en   = pipe_en;
    assign stat.span_zero = (dmaj_reg == '0);
    assign stat.step_last = (cnt_reg == COORD_W'(1));

    // Stage 1 arithmetic: grid check and z*d + y
    assign ing_next = s0_has_reg
                    && ({1'b0, s0_cell_reg[0]} < d_reg)
                    && ({1'b0, s0_cell_reg[1]} < d_reg)
                    && ({1'b0, s0_cell_reg[2]} < d_reg);
    assign row_next = ROW_W'(s0_cell_reg[2]) * ROW_W'(d_reg) + ROW_W'(s0_cell_reg[1]);

    // Output arithmetic: row*d + x
    assign idx_full = PROD_W'(s1_row_reg) * PROD_W'(d_reg) + PROD_W'(s1_cell_reg[0]);

    // Hold control state: grid size and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg         <= GRID_DIM_SZ;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                d_reg <= (cfg_data > GRID_DIM_SZ) ? GRID_DIM_SZ : cfg_data;
            end
            if (pipe_en)
            begin
                s0_valid_reg  <= cmd.step;
                s1_valid_reg  <= s0_valid_reg;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Advance walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pos_reg[a] <= s_tdata[a*COORD_W +: COORD_W];
                end_reg[a] <= s_tdata[(a+3)*COORD_W +: COORD_W];
            end
        end
        if (cmd.setup)
        begin
            dif_reg   <= dif_next;
            dir_reg   <= dir_next;
            major_reg <= major_next;
            dmaj_reg  <= dmaj_next;
        end
        if (cmd.init)
        begin
            err_reg <= err_seed;
            cnt_reg <= dmaj_reg;
        end
        if (cmd.step && (dmaj_reg != '0))
        begin
            pos_reg <= pos_step;
            err_reg <= err_step;
            cnt_reg <= cnt_reg - COORD_W'(1);
        end
    end

    // Advance pipeline payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            if (cmd.step)
            begin
                if (dmaj_reg == '0)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        s0_cell_reg[a] <= '0;
                    end
                    s0_has_reg  <= 1'b0;
                    s0_last_reg <= 1'b1;
                end
                else
                begin
                    s0_cell_reg <= pos_step;
                    s0_has_reg  <= 1'b1;
                    s0_last_reg <= (cnt_reg == COORD_W'(1));
                end
            end
            s1_cell_reg   <= s0_cell_reg;
            s1_row_reg    <= row_next;
            s1_ing_reg    <= ing_next;
            s1_has_reg    <= s0_has_reg;
            s1_last_reg   <= s0_last_reg;
            out_cell_reg  <= s1_cell_reg;
            out_index_reg <= s1_ing_reg ? idx_full[INDEX_W-1:0] : '0;
            out_ing_reg   <= s1_ing_reg;
            out_has_reg   <= s1_has_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_index_reg, out_cell_reg[2], out_cell_reg[1],
                                 out_cell_reg[0]});
    assign m_tuser  = {out_has_reg, out_ing_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/voxel_line_cell_walker_chk.sv
`include "voxel_line_cell_walker_assert.svh"

module voxel_line_cell_walker_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [vlcw_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [vlcw_pkg::M_USER_W-1:0] m_tuser,
    input  logic                          m_tlast
);
    // A stalled result beat stays valid
    `VLCW_CHECK_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

    // A stalled result beat keeps its payload
    `VLCW_CHECK_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    // The empty result is all zero and closes its segment
    `VLCW_CHECK(a_empty_form, m_tvalid && !m_tuser[1], m_tlast && (m_tdata == '0) && !m_tuser[0], "malformed empty result")

    // A cell outside the grid carries index zero
    `VLCW_CHECK(a_off_grid_index, m_tvalid && !m_tuser[0], m_tdata[35:18] == '0, "nonzero index for a cell outside the grid")

endmodule

bind voxel_line_cell_walker voxel_line_cell_walker_chk u_chk (.*);
